// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro samples on i_clk; the reset-aware ones are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Implication into the next cycle, disabled during reset.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

// Implication into the next cycle, active during reset too.
`define CHK_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication (always on)");

`endif

// ===== hw/rtl/hsv2rgb_pkg.sv =====
// Types and constants for the HSV to RGB converter.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam logic [16:0] UNIT       = 17'h10000;    // 1.0 in UQ1.16
    localparam logic [15:0] HUE_TURN   = 16'd23040;    // 360 deg * 64
    localparam logic [15:0] HUE_SECTOR = 16'd3840;     // 60 deg * 64

    // frac = (rem << 16) / 3840 = (rem << 8) / 15, done as
    // (rem * ceil(2^23 / 15)) >> 15; exact for rem < 3840
    localparam logic [19:0] FRAC_RECIP = 20'd559241;

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } t_sector;

    typedef struct packed {
        logic [15:0] hue;
        logic [16:0] saturation;
        logic [16:0] brightness;
        logic [16:0] alpha_in;
    } t_hsv;

    typedef struct packed {
        logic [16:0] red;
        logic [16:0] green;
        logic [16:0] blue;
        logic [16:0] alpha_out;
    } t_rgb;

    typedef struct packed {
        t_sector     sector;
        logic [11:0] rem;       // offset within sector, 0..3839
    } t_hue_split;

    function automatic logic [16:0] clamp_unit(input logic [16:0] x);
        return (x > UNIT) ? UNIT : x;
    endfunction

endpackage

// ===== hw/rtl/hsv2rgb_sector.sv =====
// Hue decoder: maps any hue of a full turn or more to zero and splits hue into sector and offset.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_sector (
    input  logic [15:0]             i_hue,
    output hsv2rgb_pkg::t_hue_split o_split
);
    import hsv2rgb_pkg::*;

    logic [15:0] w_hue;
    logic [15:0] w_base;
    logic [15:0] w_rem;
    t_sector     w_sector;

    assign w_hue = (i_hue >= HUE_TURN) ? 16'd0 : i_hue;

    always_comb begin
        if (w_hue >= 16'(5 * HUE_SECTOR)) begin
            w_sector = SEC_M_R;
            w_base   = 16'(5 * HUE_SECTOR);
        end else if (w_hue >= 16'(4 * HUE_SECTOR)) begin
            w_sector = SEC_B_M;
            w_base   = 16'(4 * HUE_SECTOR);
        end else if (w_hue >= 16'(3 * HUE_SECTOR)) begin
            w_sector = SEC_C_B;
            w_base   = 16'(3 * HUE_SECTOR);
        end else if (w_hue >= 16'(2 * HUE_SECTOR)) begin
            w_sector = SEC_G_C;
            w_base   = 16'(2 * HUE_SECTOR);
        end else if (w_hue >= HUE_SECTOR) begin
            w_sector = SEC_Y_G;
            w_base   = HUE_SECTOR;
        end else begin
            w_sector = SEC_R_Y;
            w_base   = 16'd0;
        end
    end

    assign w_rem          = w_hue - w_base;
    assign o_split.sector = w_sector;
    assign o_split.rem    = w_rem[11:0];

endmodule

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, top level: four-stage pipeline with per-stage valid bits.
// Depends on hsv2rgb_pkg and hsv2rgb_sector.
`timescale 1ns / 1ps

// One pixel in, one pixel out, at a sustained rate of one item per clock while
// i_ready stays high. From acceptance to o_valid: stage 1 decodes hue
// into sector and offset and clamps S and V; stage 2 forms the sector fraction
// and p; stage 3 forms s*frac and s*(1-frac); stage 4 forms q and t and routes
// p, q, t, v to the channels into the output register. Each stage is at most one
// multiply deep; stages 2 to 4 each run two multiplies side by side. Every stage
// has its own valid bit, so bubbles close up, and the input keeps accepting while
// a finished pixel waits at the output until the three stages behind it are full.
// o_ready follows i_ready combinationally through the stage enables.
// Zero saturation needs no special path: p, q and t all equal v then.
// Alpha is carried through unchanged.
module hsv_to_rgb_converter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hsv2rgb_pkg::t_hsv i_pixel,
    output logic              o_valid,
    input  logic              i_ready,
    output hsv2rgb_pkg::t_rgb o_pixel
);
    import hsv2rgb_pkg::*;

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: hue split, clamps
    t_hue_split  n_split;
    t_hue_split  r_s1_split;
    logic [16:0] r_s1_s, r_s1_v, r_s1_a;

    hsv2rgb_sector u_sector (
        .i_hue   (i_pixel.hue),
        .o_split (n_split)
    );

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_split <= n_split;
            r_s1_s     <= clamp_unit(i_pixel.saturation);
            r_s1_v     <= clamp_unit(i_pixel.brightness);
            r_s1_a     <= i_pixel.alpha_in;
        end
    end

    // ---------------- stage 2: frac and p
    logic [31:0] w_frac_prod;
    logic [33:0] w_p_prod;
    t_sector     r_s2_sector;
    logic [15:0] r_s2_frac;
    logic [16:0] r_s2_p, r_s2_s, r_s2_v, r_s2_a;

    assign w_frac_prod = {20'd0, r_s1_split.rem} * {12'd0, FRAC_RECIP};
    assign w_p_prod    = {17'd0, r_s1_v} * {17'd0, UNIT - r_s1_s};

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_sector <= r_s1_split.sector;
            r_s2_frac   <= w_frac_prod[30:15];
            r_s2_p      <= w_p_prod[32:16];
            r_s2_s      <= r_s1_s;
            r_s2_v      <= r_s1_v;
            r_s2_a      <= r_s1_a;
        end
    end

    // ---------------- stage 3: s*frac, s*(1-frac)
    logic [33:0] w_sf_prod, w_sfc_prod;
    t_sector     r_s3_sector;
    logic [16:0] r_s3_sf, r_s3_sfc, r_s3_p, r_s3_v, r_s3_a;

    assign w_sf_prod  = {17'd0, r_s2_s} * {18'd0, r_s2_frac};
    assign w_sfc_prod = {17'd0, r_s2_s} * {17'd0, UNIT - {1'b0, r_s2_frac}};

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_sector <= r_s2_sector;
            r_s3_sf     <= w_sf_prod[32:16];
            r_s3_sfc    <= w_sfc_prod[32:16];
            r_s3_p      <= r_s2_p;
            r_s3_v      <= r_s2_v;
            r_s3_a      <= r_s2_a;
        end
    end

    // ---------------- stage 4: q, t and channel routing
    logic [33:0] w_q_prod, w_t_prod;
    logic [16:0] w_q, w_t;
    t_rgb        n_out;
    t_rgb        r_out;

    assign w_q_prod = {17'd0, r_s3_v} * {17'd0, UNIT - r_s3_sf};
    assign w_t_prod = {17'd0, r_s3_v} * {17'd0, UNIT - r_s3_sfc};
    assign w_q      = w_q_prod[32:16];
    assign w_t      = w_t_prod[32:16];

    always_comb begin
        n_out.alpha_out = r_s3_a;
        case (r_s3_sector)
            SEC_R_Y: begin
                n_out.red = r_s3_v; n_out.green = w_t;    n_out.blue = r_s3_p;
            end
            SEC_Y_G: begin
                n_out.red = w_q;    n_out.green = r_s3_v; n_out.blue = r_s3_p;
            end
            SEC_G_C: begin
                n_out.red = r_s3_p; n_out.green = r_s3_v; n_out.blue = w_t;
            end
            SEC_C_B: begin
                n_out.red = r_s3_p; n_out.green = w_q;    n_out.blue = r_s3_v;
            end
            SEC_B_M: begin
                n_out.red = w_t;    n_out.green = r_s3_p; n_out.blue = r_s3_v;
            end
            default: begin
                n_out.red = r_s3_v; n_out.green = r_s3_p; n_out.blue = w_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out <= n_out;
        end
    end

    assign o_pixel = r_out;

endmodule

// ===== hw/rtl/hsv2rgb_checker.sv =====
// Port-level checker for hsv_to_rgb_converter, bound to the top level below.
// Depends on hsv2rgb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsv2rgb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input hsv2rgb_pkg::t_hsv i_pixel,
    input logic              o_valid,
    input logic              i_ready,
    input hsv2rgb_pkg::t_rgb o_pixel
);
    import hsv2rgb_pkg::*;

    // reset empties the pipeline
    `CHK_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_valid)

    // a stalled output item holds
    `CHK_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_pixel))

    // free-flowing item comes out with its alpha while the receiver stays ready
    `CHK_NEXT(a_latency_alpha, (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready, o_valid && (o_pixel.alpha_out == $past(i_pixel.alpha_in, 4)))

    // zero saturation gives grey
    `CHK_NEXT(a_grey, (i_valid && o_ready && (i_pixel.saturation == 17'd0)) ##1 i_ready ##1 i_ready ##1 i_ready, (o_pixel.red == o_pixel.green) && (o_pixel.green == o_pixel.blue))

    // no channel exceeds 1.0
    `CHK_SAME(a_range, o_valid, (o_pixel.red <= UNIT) && (o_pixel.green <= UNIT) && (o_pixel.blue <= UNIT))

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for hsv_to_rgb_converter: random and directed pixels,
// bursty sender, stalling receiver, in-order compare against a local predictor.
// Depends on hsv2rgb_pkg and the hsv_to_rgb_converter RTL.
`timescale 1ns / 1ps

module tb_top;
    import hsv2rgb_pkg::*;

    localparam int RANDOM_PIXELS = 450;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RX_HOLD_LEN   = 60;

    typedef struct {
        t_hsv pix;
        bit   drain;    // wait for all outstanding results before sending
    } t_hsv_job;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_hsv i_pixel = '0;
    logic o_ready;
    logic o_valid;
    t_rgb o_pixel;

    t_hsv_job pixel_jobs_q[$];
    t_rgb     rgb_expected_q[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       rx_hold_left   = 0;
    int       tx_gap_left    = 0;
    int       tx_burst_left  = 0;

    hsv_to_rgb_converter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pixel (o_pixel)
    );

    always #5 i_clk = ~i_clk;

    // Predicted output pixel for one input pixel.
    function automatic t_rgb rgb_from_hsv(t_hsv px);
        logic [63:0] hue, sat, val, rem, frac, p, q, t;
        t_sector     sec;
        t_rgb        res;
        hue = 64'(px.hue);
        sat = (px.saturation > UNIT) ? 64'(UNIT) : 64'(px.saturation);
        val = (px.brightness > UNIT) ? 64'(UNIT) : 64'(px.brightness);
        res.alpha_out = px.alpha_in;
        if (sat == 0) begin
            res.red   = val[16:0];
            res.green = val[16:0];
            res.blue  = val[16:0];
        end else begin
            if (hue >= 64'(HUE_TURN)) hue = 0;
            sec  = t_sector'(hue / 64'(HUE_SECTOR));
            rem  = hue % 64'(HUE_SECTOR);
            frac = (rem << 16) / 64'(HUE_SECTOR);
            p = (val * (64'(UNIT) - sat)) >> 16;
            q = (val * (64'(UNIT) - ((sat * frac) >> 16))) >> 16;
            t = (val * (64'(UNIT) - ((sat * (64'(UNIT) - frac)) >> 16))) >> 16;
            case (sec)
                SEC_R_Y: begin res.red = val[16:0]; res.green = t[16:0]; res.blue = p[16:0]; end
                SEC_Y_G: begin res.red = q[16:0]; res.green = val[16:0]; res.blue = p[16:0]; end
                SEC_G_C: begin res.red = p[16:0]; res.green = val[16:0]; res.blue = t[16:0]; end
                SEC_C_B: begin res.red = p[16:0]; res.green = q[16:0]; res.blue = val[16:0]; end
                SEC_B_M: begin res.red = t[16:0]; res.green = p[16:0]; res.blue = val[16:0]; end
                default: begin res.red = val[16:0]; res.green = p[16:0]; res.blue = q[16:0]; end
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_pixel(logic [15:0] h, logic [16:0] s, logic [16:0] v,
                               logic [16:0] a, bit drain);
        t_hsv_job job;
        job.pix.hue        = h;
        job.pix.saturation = s;
        job.pix.brightness = v;
        job.pix.alpha_in   = a;
        job.drain          = drain;
        pixel_jobs_q.push_back(job);
    endtask

    // Mostly in-range pixels with a bias toward edges; the rest use every bit.
    task automatic queue_random_pixel(bit drain);
        logic [15:0] h;
        logic [16:0] s, v, a;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            h = 16'($urandom_range(0, 65535));
            s = 17'($urandom_range(0, 131071));
            v = 17'($urandom_range(0, 131071));
            a = 17'($urandom_range(0, 131071));
        end else begin
            h = 16'($urandom_range(0, 23039));
            s = 17'($urandom_range(0, 65536));
            v = 17'($urandom_range(0, 65536));
            a = 17'($urandom_range(0, 65536));
            if (pick < 32) s = '0;
            else if (pick < 40) s = UNIT;
            if (pick >= 90) h = 16'(3840 * $urandom_range(0, 5) + $urandom_range(0, 3) +
                                    ($urandom_range(0, 1) ? 0 : 3836));
            if (h >= HUE_TURN) h = HUE_TURN - 1;
        end
        queue_pixel(h, s, v, a, drain);
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        bit       accepted;
        bit       next_valid;
        t_hsv_job job;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            accepted = i_valid && o_ready;
            if (accepted) rgb_expected_q.push_back(rgb_from_hsv(i_pixel));
            if (!(i_valid && !accepted)) begin
                next_valid = 1'b0;
                if (tx_gap_left > 0 && rx_hold_left == 0) begin
                    tx_gap_left--;
                end else if (pixel_jobs_q.size() != 0) begin
                    if (!(pixel_jobs_q[0].drain &&
                          (accepted || rgb_expected_q.size() != 0))) begin
                        job = pixel_jobs_q.pop_front();
                        i_pixel <= job.pix;
                        next_valid = 1'b1;
                        if (tx_burst_left > 0) tx_burst_left--;
                        if (tx_burst_left == 0) begin
                            tx_burst_left = $urandom_range(1, 30);
                            tx_gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end
                i_valid <= next_valid;
            end
        end
    end

    // Receiver: stall pattern is redrawn at random intervals; long hold-offs
    // let the pipeline fill and push back on the input.
    int rx_mode       = 0;
    int rx_mode_left  = 0;
    int rx_phase      = 0;
    int results_seen  = 0;
    int next_hold_at  = 100;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) results_seen++;
            if (results_seen >= next_hold_at) begin
                rx_hold_left = RX_HOLD_LEN;
                next_hold_at += 250;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(20, 80);
                end
                rx_mode_left--;
                rx_phase = (rx_phase + 1) % 3;
                case (rx_mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= (rx_phase != 0);
                endcase
            end
        end
    end

    // Monitor: in-order compare of each output item
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_valid && i_ready) begin
            if (rgb_expected_q.size() == 0) begin
                report_mismatch("unexpected output item");
            end else begin
                want = rgb_expected_q.pop_front();
                if (o_pixel.red !== want.red)
                    report_mismatch($sformatf("red: got %0d expected %0d",
                                              o_pixel.red, want.red));
                if (o_pixel.green !== want.green)
                    report_mismatch($sformatf("green: got %0d expected %0d",
                                              o_pixel.green, want.green));
                if (o_pixel.blue !== want.blue)
                    report_mismatch($sformatf("blue: got %0d expected %0d",
                                              o_pixel.blue, want.blue));
                if (o_pixel.alpha_out !== want.alpha_out)
                    report_mismatch($sformatf("alpha_out: got %0d expected %0d",
                                              o_pixel.alpha_out, want.alpha_out));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        // directed: sector edges, wrap of hue, grey, clamping, alpha extremes
        queue_pixel(16'd0,     UNIT,       UNIT,       UNIT,       1'b0);
        queue_pixel(16'd3839,  UNIT,       UNIT,       17'd0,      1'b0);
        queue_pixel(16'd3840,  UNIT,       17'd50000,  17'd1234,   1'b0);
        queue_pixel(16'd7680,  17'd40000,  UNIT,       17'd131071, 1'b0);
        queue_pixel(16'd11520, 17'd32768,  17'd65535,  17'd7,      1'b0);
        queue_pixel(16'd15360, 17'd1,      UNIT,       UNIT,       1'b0);
        queue_pixel(16'd19200, 17'd65535,  17'd1,      17'd99,     1'b0);
        queue_pixel(16'd23039, UNIT,       UNIT,       17'd5,      1'b0);
        queue_pixel(16'd23040, 17'd30000,  17'd60000,  17'd6,      1'b0);
        queue_pixel(16'd65535, UNIT,       UNIT,       17'd131071, 1'b0);
        queue_pixel(16'd5000,  17'd0,      17'd40000,  17'd77,     1'b0);
        queue_pixel(16'd12345, 17'd0,      17'd131071, 17'd0,      1'b0);
        queue_pixel(16'd9000,  17'd131071, 17'd45000,  17'd88,     1'b0);
        queue_pixel(16'd17000, 17'd70000,  17'd131071, 17'd65537,  1'b0);
        queue_pixel(16'd2000,  UNIT,       17'd0,      UNIT,       1'b0);
        queue_pixel(16'd13000, 17'd20000,  17'd0,      17'd3,      1'b0);
        queue_pixel(16'd21000, 17'd98304,  17'd98304,  17'd98304,  1'b0);
        queue_pixel(16'd1920,  17'd65535,  17'd65535,  17'd65535,  1'b0);
        queue_pixel(16'd32768, 17'd10000,  17'd20000,  17'd30000,  1'b0);
        for (int k = 0; k < RANDOM_PIXELS; k++)
            queue_random_pixel(k == 0 || k == RANDOM_PIXELS / 2);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pixel_jobs_q.size() != 0 || i_valid) @(posedge i_clk);
        while (rgb_expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_sector.sv
hw/rtl/hsv_to_rgb_converter.sv
hw/rtl/hsv2rgb_checker.sv
tb/tb_top.sv
